// ===== hdl/twts_pkg.sv =====
// package with types, constants and helpers for the timing wheel timer scheduler
package twts_pkg;

  localparam int SLOTS_DEF    = 256;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_SET     = 2'd1,
    KIND_CANCEL  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_ZERO      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DUP       = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SET_WR,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_WALK_DO,
    S_EMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] timer_id;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] result_id;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

endpackage

// ===== hdl/twts_slot_mem.sv =====
// slot head and tail memory with a clearing pass after reset
module twts_slot_mem
  import twts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int PW    = 7,
  parameter int SW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [SW-1:0] rd_addr,
  output logic [PW-1:0] rd_head,
  output logic [PW-1:0] rd_tail,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [PW-1:0] wr_head,
  input  logic [PW-1:0] wr_tail,
  input  logic [PW-1:0] nil_val,
  output logic          busy
);

  logic [2*PW-1:0] mem [SLOTS];
  logic [SW:0]     clr_r;
  logic [SW:0]     clr_nxt;

  assign busy    = (clr_r != SW'(0) + (SW+1)'(SLOTS));
  assign clr_nxt = busy ? clr_r + 1'b1 : clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_r[SW-1:0]] <= {nil_val, nil_val};
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_head, wr_tail};
    end
    {rd_head, rd_tail} <= mem[rd_addr];
  end

endmodule

// ===== hdl/timing_wheel_timer_scheduler_unit.sv =====
// top level of the timing wheel timer scheduler
// set/cancel: S_SCAN (one table entry compared per cycle), S_SET_WR, S_DONE; a stored set
// adds S_HEAD_RD and S_HEAD_WAIT; tick: S_HEAD_RD, S_HEAD_WAIT, per slot list entry S_WALK,
// S_WALK_WAIT and S_WALK_DO, S_EMIT per expired timer, S_DONE if any expires
// in_stall is high while an item is at work; a waiting result holds only the output step
// reset: synchronous; the slot memory is cleared slot by slot, no item taken meanwhile
module timing_wheel_timer_scheduler_unit
  import twts_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int EW = $clog2(CAPACITY);
  localparam int SW = $clog2(SLOTS);
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] found_r, found_nxt;
  logic [PW-1:0] free_r, free_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] prev_r, prev_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  out_item_t     pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt, canc_r, canc_nxt;
  out_item_t obuf_r, obuf_nxt;
  logic      ov_r, ov_nxt;

  logic [15:0]   ident_m [CAPACITY];
  logic [15:0]   rounds_m [CAPACITY];
  logic [PW-1:0] link_m [CAPACITY];
  logic [15:0]   ident_q;
  logic [15:0]   rounds_q;
  logic [PW-1:0] link_q;
  logic [EW-1:0] rd_e;
  logic          ent_we, link_we, rnd_we;
  logic [EW-1:0] ent_a, link_a, rnd_a;
  logic [PW-1:0] ent_link, link_d;
  logic [15:0]   ent_id, ent_rnd, rnd_d;

  logic [SW-1:0] sm_ra, sm_wa;
  logic [PW-1:0] sm_h, sm_t, sm_wh, sm_wt;
  logic          sm_we, sm_busy;
  logic [SW:0]   slot_sum;
  logic [EW-1:0] idx_e, cur_e;

  assign idx_e = idx_r[EW-1:0];
  assign cur_e = cur_r[EW-1:0];

  twts_slot_mem #(.SLOTS(SLOTS), .PW(PW), .SW(SW)) u_slot (
    .clk(clk), .rst_n(rst_n), .rd_addr(sm_ra), .rd_head(sm_h), .rd_tail(sm_t),
    .wr_en(sm_we), .wr_addr(sm_wa), .wr_head(sm_wh), .wr_tail(sm_wt),
    .nil_val(NIL), .busy(sm_busy)
  );

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ident_m[ent_a] <= ent_id;
    end
    if (ent_we || rnd_we) begin
      rounds_m[ent_we ? ent_a : rnd_a] <= ent_we ? ent_rnd : rnd_d;
    end
    if (ent_we || link_we) begin
      link_m[ent_we ? ent_a : link_a] <= ent_we ? ent_link : link_d;
    end
    ident_q  <= ident_m[rd_e];
    rounds_q <= rounds_m[rd_e];
    link_q   <= link_m[rd_e];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= SW'(SLOTS - 1);
      valid_r  <= '0;
      canc_r   <= '0;
      ov_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      valid_r  <= valid_nxt;
      canc_r   <= canc_nxt;
      ov_r     <= ov_nxt;
      pend_v_r <= pend_v_nxt;
    end
    item_r  <= item_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    free_r  <= free_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    pend_r  <= pend_nxt;
    slot_r  <= slot_nxt;
    obuf_r  <= obuf_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = obuf_r;
  assign in_stall  = (state_r != S_IDLE) || sm_busy;
  assign slot_sum  = (SW+1)'(pos_r) + (SW+1)'(item_r.delay_ticks % SLOTS);

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    free_nxt = free_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    pend_nxt = pend_r;
    pend_v_nxt = pend_v_r;
    slot_nxt = slot_r;
    valid_nxt = valid_r;
    canc_nxt = canc_r;
    obuf_nxt = obuf_r;
    ov_nxt = ov_r && out_stall;
    rd_e = idx_e;
    ent_we = 1'b0;
    ent_a = free_r[EW-1:0];
    ent_id = item_r.timer_id;
    ent_rnd = 16'((item_r.delay_ticks - 16'd1) / SLOTS);
    ent_link = NIL;
    link_we = 1'b0;
    link_a = prev_r[EW-1:0];
    link_d = link_q;
    rnd_we = 1'b0;
    rnd_a = cur_e;
    rnd_d = rounds_q - 16'd1;
    sm_ra = slot_r;
    sm_we = 1'b0;
    sm_wa = slot_r;
    sm_wh = head_r;
    sm_wt = tail_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !sm_busy) begin
          item_nxt = in_data;
          idx_nxt = '0;
          found_nxt = NIL;
          free_nxt = NIL;
          case (action_t'(in_data.action))
            ACT_TICK: begin
              pos_nxt = (pos_r == SW'(SLOTS - 1)) ? '0 : pos_r + 1'b1;
              slot_nxt = pos_nxt;
              state_nxt = S_HEAD_RD;
            end
            ACT_SET, ACT_CANCEL: state_nxt = S_SCAN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        // one entry per cycle; read data is registered, so it belongs to the previous index
        rd_e = idx_e;
        if (idx_r != '0) begin
          if (valid_r[EW'(idx_r - 1'b1)] && !canc_r[EW'(idx_r - 1'b1)] &&
              ident_q == item_r.timer_id && found_r == NIL) begin
            found_nxt = idx_r - 1'b1;
          end
        end
        if (idx_r != NIL && !valid_r[idx_e] && free_r == NIL) begin
          free_nxt = idx_r;
        end
        if (idx_r == NIL) begin
          state_nxt = S_SET_WR;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        slot_nxt = slot_sum >= (SW+1)'(SLOTS) ? SW'(slot_sum - (SW+1)'(SLOTS))
                                               : SW'(slot_sum);
      end
      S_SET_WR: begin
        pend_nxt.result_id = item_r.timer_id;
        pend_nxt.last = 1'b1;
        pend_nxt.status = ST_OK;
        if (item_r.action == ACT_CANCEL) begin
          pend_nxt.result_kind = KIND_CANCEL;
          if (found_r == NIL) begin
            pend_nxt.status = ST_NOT_FOUND;
          end else begin
            canc_nxt[found_r[EW-1:0]] = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          pend_nxt.result_kind = KIND_SET;
          if (item_r.delay_ticks == '0) begin
            pend_nxt.status = ST_ZERO;
            state_nxt = S_DONE;
          end else if (found_r != NIL) begin
            pend_nxt.status = ST_DUP;
            state_nxt = S_DONE;
          end else if (free_r == NIL) begin
            pend_nxt.status = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_HEAD_RD;
          end
        end
      end
      S_HEAD_RD: begin
        if (item_r.action == ACT_SET) begin
          ent_we = 1'b1;
        end
        state_nxt = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        head_nxt = sm_h;
        tail_nxt = sm_t;
        if (item_r.action == ACT_SET) begin
          valid_nxt[free_r[EW-1:0]] = 1'b1;
          canc_nxt[free_r[EW-1:0]] = 1'b0;
          if (sm_t != NIL) begin
            link_we = 1'b1;
            link_a = sm_t[EW-1:0];
            link_d = free_r;
          end else begin
            head_nxt = free_r;
          end
          tail_nxt = free_r;
          state_nxt = S_DONE;
          sm_we = 1'b1;
          sm_wh = head_nxt;
          sm_wt = free_r;
        end else begin
          cur_nxt = sm_h;
          prev_nxt = NIL;
          idx_nxt = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        rd_e = cur_e;
        if (cur_r == NIL || idx_r == NIL) begin
          sm_we = 1'b1;
          if (pend_v_r) begin
            pend_nxt.last = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        rd_e = cur_e;
        state_nxt = S_WALK_DO;
      end
      S_WALK_DO: begin
        rd_e = cur_e;
        idx_nxt = idx_r + 1'b1;
        cur_nxt = link_q;
        if (!canc_r[cur_e] && rounds_q != '0) begin
          rnd_we = 1'b1;
          prev_nxt = cur_r;
          state_nxt = S_WALK;
        end else begin
          if (prev_r != NIL) begin
            link_we = 1'b1;
          end else begin
            head_nxt = link_q;
          end
          if (tail_r == cur_r) begin
            tail_nxt = prev_r;
          end
          valid_nxt[cur_e] = 1'b0;
          canc_nxt[cur_e] = 1'b0;
          if (!canc_r[cur_e]) begin
            cur_nxt = cur_r;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_EMIT: begin
        // hold one expiry back so the final one can carry last
        rd_e = cur_e;
        if (!ov_r || !out_stall) begin
          if (pend_v_r) begin
            ov_nxt = 1'b1;
            obuf_nxt = pend_r;
          end
          pend_nxt.result_kind = KIND_EXPIRED;
          pend_nxt.result_id = ident_q;
          pend_nxt.status = ST_OK;
          pend_nxt.last = 1'b0;
          pend_v_nxt = 1'b1;
          cur_nxt = link_q;
          state_nxt = S_WALK;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          obuf_nxt = pend_r;
          pend_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== tb/sv/timing_wheel_timer_scheduler_unit_tb.sv =====
// self-checking testbench for the timing wheel timer scheduler unit
`timescale 1ns / 100ps

module timing_wheel_timer_scheduler_unit_tb;
  import twts_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int NENT  = CAPACITY_DEF;
  localparam int NDIR  = 22;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  timing_wheel_timer_scheduler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // wheel shadow state
  logic [7:0]  wheel_pos;
  int          head_q[NSLOT];
  int          tail_q[NSLOT];
  bit          ent_live[NENT];
  bit          ent_cxl[NENT];
  logic [15:0] ent_id[NENT];
  int          ent_rounds[NENT];
  int          ent_next[NENT];

  out_item_t   pending_results[$];
  int          errors;
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  bit          hold_off;

  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp;
  } dir_row_t;
  dir_row_t dir_tab[NDIR];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("timing_wheel_timer_scheduler_unit regression: fail");
    $finish;
  end

  function automatic out_item_t mk_res(logic [1:0] k, logic [15:0] id, logic [2:0] st,
                                       logic lst);
    out_item_t r;
    r.result_kind = k;
    r.result_id   = id;
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  function automatic int find_timer(logic [15:0] id);
    for (int i = 0; i < NENT; i++)
      if (ent_live[i] && !ent_cxl[i] && ent_id[i] == id) return i;
    return NENT;
  endfunction

  task automatic wheel_reset();
    wheel_pos = 8'(NSLOT - 1);
    for (int i = 0; i < NSLOT; i++) begin
      head_q[i] = NENT;
      tail_q[i] = NENT;
    end
    for (int i = 0; i < NENT; i++) begin
      ent_live[i] = 0;
      ent_cxl[i]  = 0;
      ent_next[i] = NENT;
    end
  endtask

  task automatic predict_item(in_item_t it);
    int e;
    int s;
    int cur;
    int prv;
    int nxt;
    int n;
    status_t st;
    out_item_t fired[$];
    case (action_t'(it.action))
      ACT_TICK: begin
        wheel_pos = wheel_pos + 8'd1;
        s = wheel_pos;
        cur = head_q[s];
        prv = NENT;
        n = 0;
        while (cur < NENT && n < NENT) begin
          n++;
          nxt = ent_next[cur];
          if (!ent_cxl[cur] && ent_rounds[cur] > 0) begin
            ent_rounds[cur]--;
            prv = cur;
          end else begin
            if (prv < NENT) ent_next[prv] = nxt;
            else head_q[s] = nxt;
            if (tail_q[s] == cur) tail_q[s] = prv;
            if (!ent_cxl[cur]) fired.push_back(mk_res(KIND_EXPIRED, ent_id[cur], ST_OK, 1'b0));
            ent_live[cur] = 0;
            ent_cxl[cur]  = 0;
          end
          cur = nxt;
        end
        if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
        foreach (fired[i]) pending_results.push_back(fired[i]);
      end
      ACT_SET: begin
        e = NENT;
        if (it.delay_ticks == 0) st = ST_ZERO;
        else if (find_timer(it.timer_id) != NENT) st = ST_DUP;
        else begin
          for (int i = NENT - 1; i >= 0; i--) if (!ent_live[i]) e = i;
          st = (e == NENT) ? ST_FULL : ST_OK;
        end
        if (st == ST_OK) begin
          s = (int'(wheel_pos) + int'(it.delay_ticks)) % NSLOT;
          ent_live[e] = 1;
          ent_cxl[e] = 0;
          ent_id[e] = it.timer_id;
          ent_rounds[e] = (int'(it.delay_ticks) - 1) / NSLOT;
          ent_next[e] = NENT;
          if (tail_q[s] < NENT) ent_next[tail_q[s]] = e;
          else head_q[s] = e;
          tail_q[s] = e;
        end
        pending_results.push_back(mk_res(KIND_SET, it.timer_id, st, 1'b1));
      end
      ACT_CANCEL: begin
        e = find_timer(it.timer_id);
        if (e < NENT) ent_cxl[e] = 1;
        pending_results.push_back(mk_res(KIND_CANCEL, it.timer_id,
                                         (e < NENT) ? ST_OK : ST_NOT_FOUND, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic send_item(in_item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_checked(in_item_t it);
    predict_item(it);
    send_item(it);
  endtask

  function automatic in_item_t mk_item(action_t a, logic [15:0] id, logic [15:0] d);
    in_item_t it;
    it.action = a;
    it.timer_id = id;
    it.delay_ticks = d;
    return it;
  endfunction

  task automatic wait_drained();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_results.size() > 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (NENT * 5 + 20) @(posedge clk);
  endtask

  function automatic in_item_t rand_item(int nid);
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it.timer_id = 16'($urandom_range(nid - 1));
    if ($urandom_range(9) == 0) it.timer_id = 16'($urandom);
    if ($urandom_range(3) == 0) it.delay_ticks = 16'($urandom_range(12));
    else if ($urandom_range(4) == 0) it.delay_ticks = 16'($urandom);
    else it.delay_ticks = 16'($urandom_range(600));
    if (r < 45) it.action = ACT_TICK;
    else if (r < 80) it.action = ACT_SET;
    else if (r < 97) it.action = ACT_CANCEL;
    else it.action = ACT_NONE;
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result %h", out_data);
        mismatches++;
      end else begin
        exp = pending_results.pop_front();
        if (out_data.result_kind !== exp.result_kind || out_data.result_id !== exp.result_id ||
            out_data.status !== exp.status || out_data.last !== exp.last) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: expected kind %0d id %h st %0d last %0d, got %0d %h %0d %0d",
                     exp.result_kind, exp.result_id, exp.status, exp.last,
                     out_data.result_kind, out_data.result_id, out_data.status,
                     out_data.last);
          mismatches++;
        end
      end
    end
  end

  // receiver stall
  int hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_off) begin
      hold_cnt  <= hold_cnt + 1;
      out_stall <= (hold_cnt < 3000);
    end else begin
      hold_cnt  <= 0;
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    in_item_t it;
    errors = 0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    wheel_reset();

    dir_tab[0]  = '{mk_item(ACT_CANCEL, 16'h0000, 16'h0000), 1,
                    mk_res(KIND_CANCEL, 16'h0000, ST_NOT_FOUND, 1)};
    dir_tab[1]  = '{mk_item(ACT_SET, 16'hFFFF, 16'h0000), 1,
                    mk_res(KIND_SET, 16'hFFFF, ST_ZERO, 1)};
    dir_tab[2]  = '{mk_item(ACT_SET, 16'h0001, 16'h0001), 1,
                    mk_res(KIND_SET, 16'h0001, ST_OK, 1)};
    dir_tab[3]  = '{mk_item(ACT_SET, 16'h0001, 16'h0005), 1,
                    mk_res(KIND_SET, 16'h0001, ST_DUP, 1)};
    dir_tab[4]  = '{mk_item(ACT_NONE, 16'hFFFF, 16'hFFFF), 0, '0};
    dir_tab[5]  = '{mk_item(ACT_TICK, 16'h0000, 16'h0000), 1,
                    mk_res(KIND_EXPIRED, 16'h0001, ST_OK, 1)};
    dir_tab[6]  = '{mk_item(ACT_SET, 16'hFFFF, 16'hFFFF), 1,
                    mk_res(KIND_SET, 16'hFFFF, ST_OK, 1)};
    dir_tab[7]  = '{mk_item(ACT_SET, 16'h0010, 16'h0002), 0, '0};
    dir_tab[8]  = '{mk_item(ACT_SET, 16'h0011, 16'h0002), 0, '0};
    dir_tab[9]  = '{mk_item(ACT_SET, 16'h0012, 16'h0102), 0, '0};
    dir_tab[10] = '{mk_item(ACT_CANCEL, 16'h0011, 16'hFFFF), 1,
                    mk_res(KIND_CANCEL, 16'h0011, ST_OK, 1)};
    dir_tab[11] = '{mk_item(ACT_CANCEL, 16'h0011, 16'h0000), 1,
                    mk_res(KIND_CANCEL, 16'h0011, ST_NOT_FOUND, 1)};
    dir_tab[12] = '{mk_item(ACT_SET, 16'h0011, 16'h0001), 0, '0};
    dir_tab[13] = '{mk_item(ACT_TICK, 16'hFFFF, 16'hFFFF), 0, '0};
    dir_tab[14] = '{mk_item(ACT_TICK, 16'h0000, 16'h0000), 0, '0};
    dir_tab[15] = '{mk_item(ACT_SET, 16'h0020, 16'h0100), 0, '0};
    dir_tab[16] = '{mk_item(ACT_SET, 16'h0021, 16'h0101), 0, '0};
    dir_tab[17] = '{mk_item(ACT_TICK, 16'h0000, 16'h0000), 0, '0};
    dir_tab[18] = '{mk_item(ACT_CANCEL, 16'hFFFF, 16'h0000), 0, '0};
    dir_tab[19] = '{mk_item(ACT_TICK, 16'h0000, 16'h0000), 0, '0};
    dir_tab[20] = '{mk_item(ACT_SET, 16'h5555, 16'hAAAA), 0, '0};
    dir_tab[21] = '{mk_item(ACT_CANCEL, 16'hAAAA, 16'h5555), 0, '0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp) begin
        predict_item(dir_tab[i].item);
        if (pending_results.size() == 0 ||
            pending_results[pending_results.size()-1] != dir_tab[i].exp) begin
          errors++;
          $display("directed row %0d: predictor disagrees with table", i);
        end
        send_item(dir_tab[i].item);
      end else begin
        send_checked(dir_tab[i].item);
      end
    end
    wait_drained();

    // fill the table completely, then probe full
    for (int i = 0; i < NENT; i++)
      send_checked(mk_item(ACT_SET, 16'(16'h1000 + i), 16'(3 + (i % 5))));
    send_checked(mk_item(ACT_SET, 16'h2000, 16'h0003));
    for (int i = 0; i < 10; i++) send_checked(mk_item(ACT_TICK, 16'h0, 16'h0));
    wait_drained();

    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        3: begin idle_pct = 17; stall_pct = 17; end
        default: begin idle_pct = 0; stall_pct = 0; hold_off = 1; end
      endcase
      for (int k = 0; k < 63; k++) begin
        it = rand_item(ph == 4 ? 24 : 48);
        if (ph == 4 && k < 40) it.action = ACT_SET;
        if (ph == 4 && k < 40) it.delay_ticks = 16'(1 + $urandom_range(3));
        if (ph == 4 && k >= 40) it.action = ACT_TICK;
        send_checked(it);
      end
      wait_drained();
      hold_off = 0;
    end

    if (pending_results.size() > 0) errors++;
    if (errors == 0) begin
      $display("timing_wheel_timer_scheduler_unit regression: pass");
    end else begin
      $display("timing_wheel_timer_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/twts_pkg.sv
hdl/twts_slot_mem.sv
hdl/timing_wheel_timer_scheduler_unit.sv
tb/sv/timing_wheel_timer_scheduler_unit_tb.sv
